// File: rtl/core/sdnf_pkg.sv
package sdnf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int PARAM_W   = 31;
  localparam int ENERGY_W  = 48;
  localparam int CNT_W     = 5;
  localparam int CELL_W    = 8;
  localparam int NUM_W     = 66;  // dividend / radicand width of the shared unit
  localparam int DEN_W     = 34;  // divisor and root width
  localparam int MUL_W     = 35;  // multiplier operand width
  localparam int SUM_W     = 68;  // signed working sum

  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_REST      = 2'd2;

  localparam logic [PARAM_W-1:0] STIFFNESS_RESET = PARAM_W'(65536);
  localparam logic [PARAM_W-1:0] DAMPING_RESET   = '0;
  localparam logic [PARAM_W-1:0] REST_RESET      = PARAM_W'(65536);

  typedef enum logic {
    UOP_DIV,
    UOP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctrl_t;

  typedef struct packed {
    logic                         op;
    logic [VAL_W-1:0]             particle_id;
    logic [2:0][VAL_W-1:0]        pos;
    logic [2:0][VAL_W-1:0]        vel;
    logic [2:0][CELL_W-1:0]       cell_idx;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] force_sum;
    logic [PARAM_W-1:0]    tension;
    logic [VAL_W-1:0]      compression;
    logic [ENERGY_W-1:0]   energy;
    logic [CNT_W-1:0]      count;
  } result_t;

  function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(-v) : v;
  endfunction

  function automatic logic [VAL_W:0] abs33(input logic [VAL_W:0] v);
    return v[VAL_W] ? (VAL_W+1)'(-v) : v;
  endfunction

  // Clamp a 36-bit two's complement value to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat32(input logic [VAL_W+3:0] v);
    logic [VAL_W-1:0] r;
    if (v[VAL_W+3] && (v[VAL_W+2:VAL_W-1] != 4'hF)) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else if (!v[VAL_W+3] && (v[VAL_W+2:VAL_W-1] != 4'h0)) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sdnf_iter_unit.sv
module sdnf_iter_unit import sdnf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  unit_ctrl_t       ctrl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [MUL_W-1:0] mul_a,
  input  logic [MUL_W-1:0] mul_b,
  output logic [NUM_W-1:0] prod,
  output logic [NUM_W-1:0] res,
  output logic             done
);

  localparam int REM_W   = DEN_W + 3;
  localparam int STEP_W  = $clog2(NUM_W + 1);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(NUM_W / 2);

  logic [NUM_W-1:0]   shreg;
  logic [REM_W-1:0]   rem;
  logic [DEN_W-1:0]   den_r;
  logic               is_sqrt;
  logic               busy;
  logic [STEP_W-1:0]  cnt;

  logic [2*MUL_W-1:0] prod_full;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [REM_W:0]     diff;
  logic               ge;

  assign prod_full = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

  // Divide brings in one dividend bit per step, root extraction two radicand bits.
  assign rem_sh = is_sqrt ? {rem[REM_W-3:0], shreg[NUM_W-1 -: 2]}
                          : {rem[REM_W-2:0], shreg[NUM_W-1]};
  assign trial  = is_sqrt ? {1'b0, res[DEN_W-1:0], 2'b01} : {3'b000, den_r};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign ge     = ~diff[REM_W];

  always_ff @(posedge clk) begin
    prod <= prod_full[NUM_W-1:0];
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        shreg   <= num;
        den_r   <= den;
        rem     <= '0;
        res     <= '0;
        is_sqrt <= (ctrl.op == UOP_SQRT);
        cnt     <= (ctrl.op == UOP_SQRT) ? SQRT_STEPS : DIV_STEPS;
        busy    <= 1'b1;
      end else if (busy) begin
        shreg <= is_sqrt ? {shreg[NUM_W-3:0], 2'b00} : {shreg[NUM_W-2:0], 1'b0};
        rem   <= ge ? diff[REM_W-1:0] : rem_sh;
        res   <= {res[NUM_W-2:0], ge};
        cnt   <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/sdnf_seq.sv
module sdnf_seq import sdnf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [PARAM_W-1:0] stiffness,
  input  logic [PARAM_W-1:0] damping,
  input  logic [PARAM_W-1:0] rest_len,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              item,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            result
);

  typedef enum logic [4:0] {
    S_IDLE, S_EMIT, S_DSQ_MUL, S_DSQ_ACC, S_DSQRT, S_DSQRT_WAIT,
    S_PDOT_MUL, S_PDOT_ACC, S_PCHECK, S_PVV_MUL, S_PVV_ACC, S_PSQRT, S_PWAIT,
    S_FK_MUL, S_FK_ACC, S_FC_MUL, S_FC_ACC, S_FSAT, S_TUPD,
    S_EDIV, S_EWAIT, S_EADD, S_GMUL, S_GDIV, S_GWAIT, S_FINISH
  } state_t;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [CNT_W-1:0]    COUNT_MAX  = '1;
  localparam logic [1:0]          LAST_COMP  = 2'd2;

  state_t                  state;
  logic [VAL_W-1:0]        own_id;
  logic [2:0][VAL_W-1:0]   own_pos;
  logic [2:0][VAL_W-1:0]   own_vel;
  logic [2:0][CELL_W-1:0]  own_cell;
  logic [2:0][VAL_W-1:0]   vel_r;
  logic [2:0][VAL_W:0]     d;
  logic [DEN_W-1:0]        sep_len;
  logic [SUM_W-1:0]        sum;
  logic                    side;
  logic [1:0]              comp;
  logic                    neg_r;
  logic                    last_r;
  logic [DEN_W:0]          proj_a;
  logic [VAL_W-1:0]        rel;
  logic [VAL_W-1:0]        f;
  logic [ENERGY_W-1:0]     e_val;
  result_t                 acc;

  unit_ctrl_t              ctrl;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [NUM_W-1:0]        prod;
  logic [NUM_W-1:0]        res;
  logic                    u_done;

  logic [VAL_W-1:0]        sel_vel;
  logic [DEN_W:0]          dmr;
  logic [DEN_W:0]          dmr_mag;
  logic [SUM_W-1:0]        prod_s;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        f_sh;
  logic [DEN_W:0]          proj_v;
  logic [VAL_W-1:0]        f_next;
  logic [CELL_W+1:0]       cell_dist;
  logic                    eligible;
  logic [2:0][VAL_W:0]     d_in;
  logic [VAL_W:0]          fc;
  logic [VAL_W:0]          tension_sum;
  logic [VAL_W:0]          comp_sum;
  logic [ENERGY_W:0]       energy_sum;
  logic [ENERGY_W-1:0]     e_new;

  sdnf_iter_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .num   (num),
    .den   (den),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .res   (res),
    .done  (u_done)
  );

  function automatic logic [CELL_W-1:0] absdiff8(input logic [CELL_W-1:0] a,
                                                  input logic [CELL_W-1:0] b);
    return (a > b) ? CELL_W'(a - b) : CELL_W'(b - a);
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_in[i] = {own_pos[i][VAL_W-1], own_pos[i]} - {item.pos[i][VAL_W-1], item.pos[i]};
    end
  end

  assign cell_dist = (CELL_W+2)'(absdiff8(own_cell[0], item.cell_idx[0]))
                   + (CELL_W+2)'(absdiff8(own_cell[1], item.cell_idx[1]))
                   + (CELL_W+2)'(absdiff8(own_cell[2], item.cell_idx[2]));
  assign eligible  = (item.particle_id != own_id) && (cell_dist < (CELL_W+2)'(2));

  assign sel_vel = side ? vel_r[comp] : own_vel[comp];
  assign dmr     = {1'b0, sep_len} - {{(DEN_W-PARAM_W+1){1'b0}}, rest_len};
  assign dmr_mag = dmr[DEN_W] ? (DEN_W+1)'(-dmr) : dmr;
  assign prod_s  = neg_r ? SUM_W'(-{2'b00, prod}) : {2'b00, prod};
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
  assign f_sh    = sum_mag >> FRAC_BITS;
  assign proj_v  = neg_r ? (DEN_W+1)'(-{1'b0, res[DEN_W-1:0]}) : {1'b0, res[DEN_W-1:0]};

  // Pair force: magnitude truncated by the fraction shift, then clamped.
  always_comb begin
    if (sum[SUM_W-1] && (f_sh >= SUM_W'(64'h8000_0000))) begin
      f_next = {1'b1, {(VAL_W-1){1'b0}}};
    end else if (!sum[SUM_W-1] && (f_sh >= SUM_W'(64'h7FFF_FFFF))) begin
      f_next = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum[SUM_W-1]) begin
      f_next = VAL_W'(-f_sh[VAL_W-1:0]);
    end else begin
      f_next = f_sh[VAL_W-1:0];
    end
  end

  assign fc          = neg_r ? {1'b0, res[VAL_W-1:0]} : (VAL_W+1)'(-{1'b0, res[VAL_W-1:0]});
  assign tension_sum = {2'b00, acc.tension} + {2'b00, f[VAL_W-2:0]};
  assign comp_sum    = {acc.compression[VAL_W-1], acc.compression} + {f[VAL_W-1], f};
  assign e_new       = (res[NUM_W-1:ENERGY_W] != '0) ? ENERGY_MAX : res[ENERGY_W-1:0];
  assign energy_sum  = {1'b0, acc.energy} + {1'b0, e_val};

  always_comb begin
    ctrl.start = 1'b0;
    ctrl.op    = UOP_DIV;
    num        = '0;
    den        = sep_len;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_DSQ_MUL: begin
        mul_a = {2'b00, abs33(d[comp])};
        mul_b = {2'b00, abs33(d[comp])};
      end
      S_PDOT_MUL: begin
        mul_a = {3'b000, abs32(sel_vel)};
        mul_b = {2'b00, abs33(d[comp])};
      end
      S_PVV_MUL: begin
        mul_a = {3'b000, abs32(sel_vel)};
        mul_b = {3'b000, abs32(sel_vel)};
      end
      S_PCHECK: begin
        ctrl.start = (sum != '0);
        num        = sum_mag[NUM_W-1:0];
      end
      S_DSQRT, S_PSQRT: begin
        ctrl.start = 1'b1;
        ctrl.op    = UOP_SQRT;
        num        = sum[NUM_W-1:0];
      end
      S_FK_MUL: begin
        mul_a = dmr_mag;
        mul_b = {{(MUL_W-PARAM_W){1'b0}}, stiffness};
      end
      S_FC_MUL: begin
        mul_a = {{(MUL_W-PARAM_W){1'b0}}, damping};
        mul_b = {3'b000, abs32(rel)};
      end
      S_TUPD: begin
        mul_a = {3'b000, abs32(f)};
        mul_b = {3'b000, abs32(f)};
      end
      S_EDIV: begin
        ctrl.start = 1'b1;
        num        = prod;
        den        = {2'b00, stiffness, 1'b0};
      end
      S_GMUL: begin
        mul_a = {3'b000, abs32(f)};
        mul_b = {2'b00, abs33(d[comp])};
      end
      S_GDIV: begin
        ctrl.start = 1'b1;
        num        = prod;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      own_id    <= '0;
      own_pos   <= '0;
      own_vel   <= '0;
      own_cell  <= '0;
      acc       <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= item.last;
            if (!item.op) begin
              own_id   <= item.particle_id;
              own_pos  <= item.pos;
              own_vel  <= item.vel;
              own_cell <= item.cell_idx;
              acc      <= '0;
              state    <= item.last ? S_EMIT : S_IDLE;
            end else if (eligible) begin
              d     <= d_in;
              vel_r <= item.vel;
              sum   <= '0;
              comp  <= '0;
              neg_r <= 1'b0;
              state <= S_DSQ_MUL;
            end else begin
              state <= item.last ? S_EMIT : S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            result    <= acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DSQ_MUL: state <= S_DSQ_ACC;
        S_DSQ_ACC: begin
          sum  <= sum + prod_s;
          comp <= comp + 1'b1;
          state <= (comp == LAST_COMP) ? S_DSQRT : S_DSQ_MUL;
        end
        S_DSQRT: state <= S_DSQRT_WAIT;
        S_DSQRT_WAIT: begin
          if (u_done) begin
            sep_len <= res[DEN_W-1:0];
            side    <= 1'b0;
            comp    <= '0;
            sum     <= '0;
            state   <= S_PDOT_MUL;
          end
        end
        S_PDOT_MUL: begin
          neg_r <= sel_vel[VAL_W-1] ^ d[comp][VAL_W];
          state <= S_PDOT_ACC;
        end
        S_PDOT_ACC: begin
          sum  <= sum + prod_s;
          comp <= comp + 1'b1;
          state <= (comp == LAST_COMP) ? S_PCHECK : S_PDOT_MUL;
        end
        S_PCHECK: begin
          // A zero dot product falls back to the full speed.
          comp <= '0;
          if (sum == '0) begin
            neg_r <= 1'b0;
            state <= S_PVV_MUL;
          end else begin
            neg_r <= sum[SUM_W-1];
            state <= S_PWAIT;
          end
        end
        S_PVV_MUL: state <= S_PVV_ACC;
        S_PVV_ACC: begin
          sum  <= sum + prod_s;
          comp <= comp + 1'b1;
          state <= (comp == LAST_COMP) ? S_PSQRT : S_PVV_MUL;
        end
        S_PSQRT: state <= S_PWAIT;
        S_PWAIT: begin
          if (u_done) begin
            comp <= '0;
            sum  <= '0;
            if (!side) begin
              proj_a <= proj_v;
              side   <= 1'b1;
              state  <= S_PDOT_MUL;
            end else begin
              rel   <= sat32({proj_a[DEN_W], proj_a} - {proj_v[DEN_W], proj_v});
              state <= S_FK_MUL;
            end
          end
        end
        S_FK_MUL: begin
          neg_r <= dmr[DEN_W];
          state <= S_FK_ACC;
        end
        S_FK_ACC: begin
          sum   <= prod_s;
          state <= S_FC_MUL;
        end
        S_FC_MUL: begin
          neg_r <= rel[VAL_W-1];
          state <= S_FC_ACC;
        end
        S_FC_ACC: begin
          sum   <= sum + prod_s;
          state <= S_FSAT;
        end
        S_FSAT: begin
          f     <= f_next;
          state <= S_TUPD;
        end
        S_TUPD: begin
          if (f[VAL_W-1]) begin
            acc.compression <= sat32({{3{comp_sum[VAL_W]}}, comp_sum});
          end else if (tension_sum[VAL_W-1]) begin
            acc.tension <= '1;
          end else begin
            acc.tension <= tension_sum[PARAM_W-1:0];
          end
          if (stiffness == '0) begin
            e_val <= ENERGY_MAX;
            state <= S_EADD;
          end else begin
            state <= S_EDIV;
          end
        end
        S_EDIV: state <= S_EWAIT;
        S_EWAIT: begin
          if (u_done) begin
            e_val <= e_new;
            state <= S_EADD;
          end
        end
        S_EADD: begin
          acc.energy <= energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
          comp       <= '0;
          state      <= (sep_len != '0) ? S_GMUL : S_FINISH;
        end
        S_GMUL: begin
          neg_r <= f[VAL_W-1] ^ d[comp][VAL_W];
          state <= S_GDIV;
        end
        S_GDIV: state <= S_GWAIT;
        S_GWAIT: begin
          if (u_done) begin
            acc.force_sum[comp] <= sat32({{4{acc.force_sum[comp][VAL_W-1]}},
                                          acc.force_sum[comp]} + {{3{fc[VAL_W]}}, fc});
            comp  <= comp + 1'b1;
            state <= (comp == LAST_COMP) ? S_FINISH : S_GMUL;
          end
        end
        S_FINISH: begin
          if (acc.count != COUNT_MAX) begin
            acc.count <= acc.count + 1'b1;
          end
          state <= last_r ? S_EMIT : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/spring_damper_neighbor_force_top.sv
// Channel   Direction  Handshake           Content
// config    in         psel/penable/pwrite stiffness, damping, rest length (APB)
// s_*       in         s_tvalid/s_tready   one particle word: load or neighbor
// m_*       out        m_tvalid/m_tready   totals word, one per word with s_tlast
//
// A load word, or a neighbor word that is skipped by the id or cell test, is taken
// with no further work. A neighbor that contributes keeps s_tready low after it is
// taken, for less time when it sits on the own particle and less again at zero
// stiffness: every square root (33 steps) and every divide (66 steps) runs bit by bit
// through the one shared divide/root unit, and every product (up to 21 per neighbor)
// goes through its single registered multiplier. A word with s_tlast also sends totals.
// Reset is synchronous and restores the register defaults and clears the particle state
// and sums. s_tready is low while a neighbor is in work; a totals word waiting on
// m_tready does not block input unless the next word also asks for totals.
module spring_damper_neighbor_force_top import sdnf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: particle_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // cell_i, cell_j, cell_k
  input  logic [247:0] s_tdata,
  // s_tuser: op (0 load own particle, 1 neighbor)
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: force_x, force_y, force_z, tension_sum, compression_sum,
  // stored_energy, neighbor_count, then four zero bits
  output logic [215:0] m_tdata
);

  logic [PARAM_W-1:0] stiffness;
  logic [PARAM_W-1:0] damping;
  logic [PARAM_W-1:0] rest_len;
  item_t              item;
  result_t            result;

  assign pready = 1'b1;

  // Registers sit at byte addresses 0, 4 and 8; the word index is paddr[3:2].
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      damping   <= DAMPING_RESET;
      rest_len  <= REST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_STIFFNESS: stiffness <= pwdata[PARAM_W-1:0];
        REG_DAMPING:   damping   <= pwdata[PARAM_W-1:0];
        REG_REST:      rest_len  <= pwdata[PARAM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STIFFNESS: prdata = {1'b0, stiffness};
      REG_DAMPING:   prdata = {1'b0, damping};
      REG_REST:      prdata = {1'b0, rest_len};
      default:       prdata = '0;
    endcase
  end

  // Unpack the input word into its fields.
  always_comb begin
    item.op          = s_tuser;
    item.last        = s_tlast;
    item.particle_id = s_tdata[31:0];
    for (int i = 0; i < 3; i++) begin
      item.pos[i]      = s_tdata[32 + 32*i +: 32];
      item.vel[i]      = s_tdata[128 + 32*i +: 32];
      item.cell_idx[i] = s_tdata[224 + 8*i +: 8];
    end
  end

  sdnf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .stiffness (stiffness),
    .damping   (damping),
    .rest_len  (rest_len),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {4'b0000, result.count, result.energy, result.compression,
                    result.tension, result.force_sum[2], result.force_sum[1],
                    result.force_sum[0]};

endmodule
